/* sv/postfix_stack_evaluator_assert.svh */
// assertion macros used by the checker file
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// antecedent and consequent start in the same cycle
`define PSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pse_pkg.sv */
// types, constants and symbol codes of the postfix stack evaluator
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned DIV_CNT_W   = $clog2(VAL_W);
  localparam int unsigned POW_CNT_W   = $clog2(VAL_W + 1);

  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_POW  = 8'h5E;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } pse_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    underflow_seen;
    logic                    overflow_seen;
    logic                    divide_by_zero_seen;
  } pse_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } pse_cell_ctl_t;

  typedef struct packed {
    logic under;
    logic over;
    logic div0;
  } pse_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_POW,
    S_EMIT
  } pse_state_e;

endpackage

/* sv/pse_if.sv */
// stream interfaces for the symbol input and the result output
interface pse_in_if;
  import pse_pkg::*;

  logic    valid;
  logic    ready;
  pse_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pse_out_if;
  import pse_pkg::*;

  logic     valid;
  logic     ready;
  pse_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/pse_stack_cell.sv */
// one entry of the shifting stack: loads from its upper or lower neighbor
module pse_stack_cell (
  input  logic                      clk_i,
  input  pse_pkg::pse_cell_ctl_t    ctl_i,
  input  logic [pse_pkg::VAL_W-1:0] prev_i,
  input  logic [pse_pkg::VAL_W-1:0] next_i,
  output logic [pse_pkg::VAL_W-1:0] value_o
);
  import pse_pkg::*;

  logic [VAL_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      value_q <= prev_i;
    end else if (ctl_i.pop) begin
      value_q <= next_i;
    end
  end

  assign value_o = value_q;
endmodule

/* sv/pse_divider.sv */
// signed 32-bit restoring divider, one quotient bit per cycle
module pse_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pse_pkg::VAL_W-1:0] dividend_i,
  input  logic [pse_pkg::VAL_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [pse_pkg::VAL_W-1:0] quotient_o
);
  import pse_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0]     rem_q;
  logic [VAL_W-1:0]     quo_q;
  logic [VAL_W-1:0]     dsr_q;
  logic                 neg_q;
  logic [VAL_W:0]       trial;
  logic [VAL_W:0]       diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[VAL_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(VAL_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // work on magnitudes, fix the sign at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[VAL_W-1] ? -dividend_i : dividend_i;
      dsr_q <= divisor_i[VAL_W-1] ? -divisor_i : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[VAL_W-1] ^ divisor_i[VAL_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[VAL_W-2:0], fits};
      rem_q <= fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q : quo_q;
endmodule

/* sv/pse_power.sv */
// saturating integer power by repeated multiply, one product per cycle
module pse_power (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pse_pkg::VAL_W-1:0] base_i,
  input  logic [pse_pkg::VAL_W-1:0] exp_i,
  output logic                      done_o,
  output logic [pse_pkg::VAL_W-1:0] result_o
);
  import pse_pkg::*;

  localparam logic [2*VAL_W-1:0] ACC_MIN_MAG = 64'h0000_0000_8000_0000;
  localparam logic [2*VAL_W-1:0] ACC_POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [2*VAL_W-1:0] ACC_INF     = 64'h0000_0001_0000_0000;

  logic                 busy_q;
  logic                 done_q;
  logic [POW_CNT_W-1:0] cnt_q;
  logic [2*VAL_W-1:0]   acc_q;
  logic [VAL_W-1:0]     mag_q;
  logic [VAL_W-1:0]     exp_q;
  logic                 neg_q;
  logic [VAL_W-1:0]     mag;
  logic                 mag_small;
  logic                 run_loop;
  logic [2*VAL_W-1:0]   acc_init;
  logic                 stop;

  assign mag       = base_i[VAL_W-1] ? -base_i : base_i;
  assign mag_small = mag <= VAL_W'(1);
  assign run_loop  = !exp_i[VAL_W-1] && !mag_small;

  // negative exponent: base 0 saturates, unit bases keep magnitude one, larger bases give zero
  always_comb begin
    if (exp_i[VAL_W-1]) begin
      if (mag == '0) begin
        acc_init = ACC_INF;
      end else if (mag == VAL_W'(1)) begin
        acc_init = (2*VAL_W)'(1);
      end else begin
        acc_init = '0;
      end
    end else if (mag_small) begin
      acc_init = (exp_i == '0) ? (2*VAL_W)'(1) : {{VAL_W{1'b0}}, mag};
    end else begin
      acc_init = (2*VAL_W)'(1);
    end
  end

  assign stop = (acc_q > ACC_MIN_MAG) || (VAL_W'(cnt_q) >= exp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= run_loop;
      done_q <= !run_loop;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (stop) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= acc_init;
      mag_q <= mag;
      exp_q <= exp_i;
      neg_q <= base_i[VAL_W-1] & exp_i[0];
    end else if (busy_q && !stop) begin
      acc_q <= {{VAL_W{1'b0}}, acc_q[VAL_W-1:0]} * {{VAL_W{1'b0}}, mag_q};
    end
  end

  always_comb begin
    if (neg_q) begin
      result_o = (acc_q >= ACC_MIN_MAG) ? ACC_MIN_MAG[VAL_W-1:0] : -acc_q[VAL_W-1:0];
    end else begin
      result_o = (acc_q > ACC_POS_MAX) ? ACC_POS_MAX[VAL_W-1:0] : acc_q[VAL_W-1:0];
    end
  end

  assign done_o = done_q;
endmodule

/* sv/postfix_stack_evaluator.sv */
// Postfix evaluator: one transaction per character. Digits and the operators + - * commit in
// the cycle they are taken, so a new character can follow in the next cycle unless the result
// of a last character finds the output full. A / runs the restoring divider that makes one
// quotient bit per cycle (a zero divisor skips it). A ^ runs the power unit that forms one
// product per cycle and stops once the magnitude passes the 32-bit range, at most 32 products.
// The stack is 64 shift cells: a push moves every entry down one cell, a pop moves every entry
// up. The result of a last character goes to an output register; the next character is taken
// while it waits, and only a second result stalls the input until the first is taken.
module postfix_stack_evaluator (
  input logic      clk_i,
  input logic      rst_ni,
  pse_in_if.sink   in_i,
  pse_out_if.source out_o
);
  import pse_pkg::*;

  pse_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  pse_flags_t       flags_q, flags_d;
  logic [SYM_W-1:0] sym_q;
  logic             last_q;
  logic             out_valid_q, out_valid_d;
  pse_out_t         out_q;
  pse_out_t         pend_q;

  logic             in_acc;
  logic             out_free;
  logic [SYM_W-1:0] cur_sym;
  logic             cur_last;
  logic [VAL_W-1:0] top_val;
  logic [VAL_W-1:0] bottom_val;
  logic             is_op;
  logic             div_zero;
  logic             pushed;
  logic [VAL_W-1:0] digit;
  logic [VAL_W-1:0] push_val;
  logic [VAL_W-1:0] final_val;
  logic [CNT_W-1:0] count_upd;
  pse_flags_t       flags_upd;
  pse_out_t         res;
  logic             commit;
  logic             div_start;
  logic             pow_start;
  logic             div_done;
  logic             pow_done;
  logic [VAL_W-1:0] div_q;
  logic [VAL_W-1:0] pow_r;
  logic             load_res;
  logic             load_pend;
  logic             hold_pend;

  pse_cell_ctl_t    ctl_top;
  pse_cell_ctl_t    ctl_rest;
  logic [VAL_W-1:0] cell_value [STACK_DEPTH];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cur_sym  = (state_q == S_IDLE) ? in_i.payload.symbol : sym_q;
  assign cur_last = (state_q == S_IDLE) ? in_i.payload.last_symbol : last_q;

  // an empty slot reads as zero
  assign top_val    = (count_q != '0) ? cell_value[0] : '0;
  assign bottom_val = (count_q >= CNT_W'(2)) ? cell_value[1] : '0;

  assign is_op    = (cur_sym == SYM_ADD) || (cur_sym == SYM_SUB) || (cur_sym == SYM_MUL) ||
                    (cur_sym == SYM_DIV) || (cur_sym == SYM_POW);
  assign div_zero = (top_val == '0);
  assign digit    = VAL_W'(cur_sym) - VAL_W'(SYM_ZERO);
  assign pushed   = is_op || (count_q < CNT_W'(STACK_DEPTH));

  always_comb begin
    unique case (cur_sym)
      SYM_ADD: push_val = bottom_val + top_val;
      SYM_SUB: push_val = bottom_val - top_val;
      SYM_MUL: push_val = bottom_val * top_val;
      SYM_DIV: push_val = div_zero ? '0 : div_q;
      SYM_POW: push_val = pow_r;
      default: push_val = digit;
    endcase
  end

  // an operator pops two and pushes one, so it never leaves the stack empty; a digit on a full stack sets overflow
  always_comb begin
    flags_upd = flags_q;
    if (is_op) begin
      count_upd = (count_q >= CNT_W'(2)) ? count_q - 1'b1 : CNT_W'(1);
      flags_upd.under = flags_q.under | (count_q < CNT_W'(2));
      flags_upd.div0  = flags_q.div0 | ((cur_sym == SYM_DIV) && div_zero);
    end else if (pushed) begin
      count_upd = count_q + 1'b1;
    end else begin
      count_upd = count_q;
      flags_upd.over = 1'b1;
    end
  end

  assign final_val                = pushed ? push_val : cell_value[0];
  assign res.value                = final_val;
  assign res.underflow_seen       = flags_upd.under;
  assign res.overflow_seen        = flags_upd.over;
  assign res.divide_by_zero_seen  = flags_upd.div0;

  always_comb begin
    state_d   = state_q;
    commit    = 1'b0;
    div_start = 1'b0;
    pow_start = 1'b0;
    load_pend = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((cur_sym == SYM_DIV) && !div_zero) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end else if (cur_sym == SYM_POW) begin
            pow_start = 1'b1;
            state_d   = S_POW;
          end else begin
            commit = 1'b1;
          end
        end
      end
      S_DIV: begin
        commit = div_done;
      end
      S_POW: begin
        commit = pow_done;
      end
      S_EMIT: begin
        if (out_free) begin
          load_pend = 1'b1;
          state_d   = S_IDLE;
        end
      end
    endcase
    if (commit) begin
      state_d = (cur_last && !out_free) ? S_EMIT : S_IDLE;
    end
  end

  assign load_res    = commit && cur_last && out_free;
  assign hold_pend   = commit && cur_last && !out_free;
  assign out_valid_d = (out_valid_q && !out_o.ready) || load_res || load_pend;

  always_comb begin
    count_d = count_q;
    flags_d = flags_q;
    if (commit) begin
      if (cur_last) begin
        count_d = '0;
        flags_d = '0;
      end else begin
        count_d = count_upd;
        flags_d = flags_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q  <= in_i.payload.symbol;
      last_q <= in_i.payload.last_symbol;
    end
    if (load_res) begin
      out_q <= res;
    end else if (load_pend) begin
      out_q <= pend_q;
    end
    if (hold_pend) begin
      pend_q <= res;
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // the top cell takes the new value; a digit pushes the rest down by one, an operator pops them up by one
  assign ctl_top.push  = commit && pushed;
  assign ctl_top.pop   = 1'b0;
  assign ctl_rest.push = commit && !is_op && pushed;
  assign ctl_rest.pop  = commit && is_op;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      pse_stack_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl_top),
        .prev_i  (push_val),
        .next_i  (cell_value[i+1]),
        .value_o (cell_value[i])
      );
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      pse_stack_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl_rest),
        .prev_i  (cell_value[i-1]),
        .next_i  (cell_value[i]),
        .value_o (cell_value[i])
      );
    end else begin : g_mid
      pse_stack_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl_rest),
        .prev_i  (cell_value[i-1]),
        .next_i  (cell_value[i+1]),
        .value_o (cell_value[i])
      );
    end
  end

  pse_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (bottom_val),
    .divisor_i  (top_val),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  pse_power u_power (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pow_start),
    .base_i   (bottom_val),
    .exp_i    (top_val),
    .done_o   (pow_done),
    .result_o (pow_r)
  );
endmodule

/* sv/pse_checker.sv */
// port-level checks of the postfix evaluator and their bind to the top level
`include "postfix_stack_evaluator_assert.svh"

module pse_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [pse_pkg::SYM_W-1:0]   in_symbol_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input pse_pkg::pse_out_t           out_payload_i
);
  import pse_pkg::*;

  `PSE_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `PSE_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_payload_i), "result changed while stalled")
  `PSE_ASSERT_NEXT(a_no_result_mid_expr, clk_i, rst_ni, in_valid_i && in_ready_i && !in_last_i && !out_valid_i, !out_valid_i, "result without a last character")
  `PSE_ASSERT_SAME(a_pow_takes_cycles, clk_i, rst_ni, in_valid_i && in_ready_i && (in_symbol_i == SYM_POW), ##1 !in_ready_i, "input taken during power")
endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_symbol_i   (in_i.payload.symbol),
  .in_last_i     (in_i.payload.last_symbol),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
